[design/htw_pkg.sv]
// Shared types and constants of the hierarchical timer wheel.
`timescale 1ns / 1ps
package htw_pkg;

    localparam int DEF_ROOT_BITS  = 8;
    localparam int DEF_LEVEL_BITS = 6;
    localparam int DEF_MAX_TIMERS = 64;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 6;
    localparam int DELAY_W  = 31;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TIME_W   = 32;
    localparam int LINK_W   = 7;
    localparam int LEVELS   = 4;
    localparam int LEVEL_W  = 2;

    localparam logic [LINK_W-1:0] NIL = 7'h7f;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACTIVE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNALLOC  = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRE = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_RD_T,
        OP_SET,
        OP_UNLINK_LD,
        OP_UNLINK_WR,
        OP_PL_RD,
        OP_PL_WR,
        OP_STATUS,
        OP_CS_RD,
        OP_HD_CLR,
        OP_LVL_INC,
        OP_W_RD,
        OP_CW_LD,
        OP_W_ADV,
        OP_TK_RD,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] code;
        logic                in_ready;
    } cmd_t;

    typedef struct packed {
        logic             clr_done;
        logic [REQ_W-1:0] req;
        logic             id_bad;
        logic             armed;
        logic             alloc;
        logic             exp_eq;
        logic             w_nil;
        logic             idx_zero;
        logic             level_last;
        logic             ri_zero;
        logic             out_free;
    } stat_t;

endpackage

[design/htw_datapath.sv]
// Timer wheel datapath: time counter, link memories, slot lists and output register.
`timescale 1ns / 1ps
module htw_datapath #(
    parameter int ROOT_BITS  = htw_pkg::DEF_ROOT_BITS,
    parameter int LEVEL_BITS = htw_pkg::DEF_LEVEL_BITS,
    parameter int MAX_TIMERS = htw_pkg::DEF_MAX_TIMERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  htw_pkg::cmd_t                 cmd,
    output htw_pkg::stat_t                stat,
    input  logic [htw_pkg::REQ_W-1:0]     in_req,
    input  logic [htw_pkg::ID_W-1:0]      in_id,
    input  logic [htw_pkg::DELAY_W-1:0]   in_delay,
    input  logic [htw_pkg::DATA_W-1:0]    in_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_kind,
    output logic [htw_pkg::STATUS_W-1:0]  out_status,
    output logic [htw_pkg::ID_W-1:0]      out_id,
    output logic [htw_pkg::DATA_W-1:0]    out_data,
    output logic                          out_last
);
    import htw_pkg::*;

    localparam int ROOT_SIZE = 1 << ROOT_BITS;
    localparam int LVL_SIZE  = 1 << LEVEL_BITS;
    localparam int NSLOTS    = ROOT_SIZE + LEVELS * LVL_SIZE;
    localparam int SLOT_W    = $clog2(NSLOTS);
    localparam int IDX_W     = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam logic [63:0] ROOT_MASK = 64'(ROOT_SIZE - 1);
    localparam logic [63:0] LVL_MASK  = 64'(LVL_SIZE - 1);

    logic [TIME_W-1:0]    cur_reg;
    logic [MAX_TIMERS-1:0] armed_reg;
    logic [MAX_TIMERS-1:0] alloc_reg;
    logic [SLOT_W-1:0]    clr_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic                 out_valid_reg;

    logic [REQ_W-1:0]     req_reg;
    logic [ID_W-1:0]      id_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic [DATA_W-1:0]    data_reg;
    logic [LINK_W-1:0]    t_reg;
    logic [LINK_W-1:0]    w_reg;
    logic [LINK_W-1:0]    nn_reg;
    logic [LINK_W-1:0]    p_reg;
    logic [LINK_W-1:0]    n_reg;
    logic [TIME_W-1:0]    exp_reg;
    logic [SLOT_W-1:0]    s_reg;
    logic                 out_kind_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic                 out_last_reg;

    logic [TIME_W-1:0]    exp_mem  [MAX_TIMERS];
    logic [DATA_W-1:0]    pay_mem  [MAX_TIMERS];
    logic [LINK_W-1:0]    next_mem [MAX_TIMERS];
    logic [LINK_W-1:0]    prev_mem [MAX_TIMERS];
    logic [SLOT_W-1:0]    slot_mem [MAX_TIMERS];
    logic [LINK_W-1:0]    head_mem [NSLOTS];
    logic [LINK_W-1:0]    tail_mem [NSLOTS];

    logic [TIME_W-1:0]    rd_exp;
    logic [DATA_W-1:0]    rd_pay;
    logic [LINK_W-1:0]    rd_next;
    logic [LINK_W-1:0]    rd_prev;
    logic [SLOT_W-1:0]    rd_slot;
    logic [LINK_W-1:0]    rd_head;
    logic [LINK_W-1:0]    rd_tail;

    logic [TIME_W-1:0]    new_exp;
    logic [SLOT_W-1:0]    place_s;
    logic [SLOT_W-1:0]    coarse_s;
    logic [SLOT_W-1:0]    root_s;
    logic [63:0]          cidx;
    logic [IDX_W-1:0]     t_idx;
    logic [IDX_W-1:0]     w_idx;
    logic [IDX_W-1:0]     rd_idx;
    logic                 timer_rd;

    logic                 hd_we, tl_we, nx_we, pv_we, sl_we, ex_we, py_we;
    logic [SLOT_W-1:0]    hd_wa, tl_wa;
    logic [LINK_W-1:0]    hd_wd, tl_wd, nx_wd, pv_wd;
    logic [IDX_W-1:0]     nx_wa, pv_wa;
    logic [SLOT_W-1:0]    hd_ra;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [TIME_W-1:0] e,
                                                  input logic [TIME_W-1:0] c);
        logic [TIME_W-1:0] gap;
        logic [63:0]       d64;
        logic [63:0]       e64;
        logic [63:0]       s64;
        gap = e - c;
        d64  = {32'd0, gap};
        e64  = {32'd0, e};
        if (gap[TIME_W-1])
        begin
            s64 = {32'd0, c} & ROOT_MASK;
        end
        else if ((d64 >> ROOT_BITS) == 64'd0)
        begin
            s64 = e64 & ROOT_MASK;
        end
        else if ((d64 >> (ROOT_BITS + LEVEL_BITS)) == 64'd0)
        begin
            s64 = 64'(ROOT_SIZE) + ((e64 >> ROOT_BITS) & LVL_MASK);
        end
        else if ((d64 >> (ROOT_BITS + 2 * LEVEL_BITS)) == 64'd0)
        begin
            s64 = 64'(ROOT_SIZE + LVL_SIZE)
                + ((e64 >> (ROOT_BITS + LEVEL_BITS)) & LVL_MASK);
        end
        else if ((d64 >> (ROOT_BITS + 3 * LEVEL_BITS)) == 64'd0)
        begin
            s64 = 64'(ROOT_SIZE + 2 * LVL_SIZE)
                + ((e64 >> (ROOT_BITS + 2 * LEVEL_BITS)) & LVL_MASK);
        end
        else
        begin
            s64 = 64'(ROOT_SIZE + 3 * LVL_SIZE)
                + ((e64 >> (ROOT_BITS + 3 * LEVEL_BITS)) & LVL_MASK);
        end
        return s64[SLOT_W-1:0];
    endfunction

    assign new_exp  = cur_reg + {1'b0, delay_reg};
    assign place_s  = slot_of(exp_reg, cur_reg);
    assign root_s   = SLOT_W'({32'd0, cur_reg} & ROOT_MASK);
    assign t_idx    = t_reg[IDX_W-1:0];
    assign w_idx    = w_reg[IDX_W-1:0];
    assign rd_idx   = (cmd.op == OP_W_RD) ? w_idx : t_idx;
    assign timer_rd = (cmd.op == OP_W_RD) || (cmd.op == OP_RD_T);
    assign hd_ra    = (cmd.op == OP_TK_RD) ? root_s : coarse_s;

    always_comb
    begin
        unique case (level_reg)
            2'd0:    cidx = ({32'd0, cur_reg} >> ROOT_BITS) & LVL_MASK;
            2'd1:    cidx = ({32'd0, cur_reg} >> (ROOT_BITS + LEVEL_BITS)) & LVL_MASK;
            2'd2:    cidx = ({32'd0, cur_reg} >> (ROOT_BITS + 2 * LEVEL_BITS)) & LVL_MASK;
            default: cidx = ({32'd0, cur_reg} >> (ROOT_BITS + 3 * LEVEL_BITS)) & LVL_MASK;
        endcase
        coarse_s = SLOT_W'(64'(ROOT_SIZE) + 64'(level_reg) * 64'(LVL_SIZE) + cidx);
    end

    always_comb
    begin
        hd_we = 1'b0;
        tl_we = 1'b0;
        nx_we = 1'b0;
        pv_we = 1'b0;
        sl_we = 1'b0;
        ex_we = 1'b0;
        py_we = 1'b0;
        hd_wa = s_reg;
        tl_wa = s_reg;
        hd_wd = NIL;
        tl_wd = NIL;
        nx_wa = t_idx;
        nx_wd = NIL;
        pv_wa = t_idx;
        pv_wd = rd_tail;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                hd_we = 1'b1;
                tl_we = 1'b1;
                hd_wa = clr_reg;
                tl_wa = clr_reg;
            end
            OP_HD_CLR:
            begin
                hd_we = 1'b1;
                tl_we = 1'b1;
            end
            OP_PL_RD:
            begin
                nx_we = 1'b1;
                sl_we = 1'b1;
            end
            OP_PL_WR:
            begin
                pv_we = 1'b1;
                tl_we = 1'b1;
                tl_wd = t_reg;
                if (rd_tail == NIL)
                begin
                    hd_we = 1'b1;
                    hd_wd = t_reg;
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = rd_tail[IDX_W-1:0];
                    nx_wd = t_reg;
                end
            end
            OP_UNLINK_WR:
            begin
                if (p_reg == NIL)
                begin
                    hd_we = 1'b1;
                    hd_wd = n_reg;
                end
                else
                begin
                    nx_we = 1'b1;
                    nx_wa = p_reg[IDX_W-1:0];
                    nx_wd = n_reg;
                end
                if (n_reg == NIL)
                begin
                    tl_we = 1'b1;
                    tl_wd = p_reg;
                end
                else
                begin
                    pv_we = 1'b1;
                    pv_wa = n_reg[IDX_W-1:0];
                    pv_wd = p_reg;
                end
            end
            OP_SET:
            begin
                ex_we = (req_reg != REQ_DELETE);
                py_we = (req_reg == REQ_ADD);
            end
            default:
            begin
                hd_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            head_mem[hd_wa] <= hd_wd;
        end
        if ((cmd.op == OP_CS_RD) || (cmd.op == OP_TK_RD))
        begin
            rd_head <= head_mem[hd_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tl_we)
        begin
            tail_mem[tl_wa] <= tl_wd;
        end
        if (cmd.op == OP_PL_RD)
        begin
            rd_tail <= tail_mem[place_s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (sl_we)
        begin
            slot_mem[t_idx] <= place_s;
        end
        if (ex_we)
        begin
            exp_mem[t_idx] <= new_exp;
        end
        if (py_we)
        begin
            pay_mem[t_idx] <= data_reg;
        end
        if (timer_rd)
        begin
            rd_next <= next_mem[rd_idx];
            rd_prev <= prev_mem[rd_idx];
            rd_slot <= slot_mem[rd_idx];
            rd_exp  <= exp_mem[rd_idx];
            rd_pay  <= pay_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            armed_reg     <= '0;
            alloc_reg     <= '0;
            clr_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_CLEAR:   clr_reg   <= clr_reg + 1'b1;
                OP_LATCH:   level_reg <= '0;
                OP_LVL_INC: level_reg <= level_reg + 1'b1;
                OP_TK_RD:   cur_reg   <= cur_reg + 1'b1;
                OP_SET:
                begin
                    armed_reg[t_idx] <= (req_reg != REQ_DELETE);
                    if (req_reg == REQ_ADD)
                    begin
                        alloc_reg[t_idx] <= 1'b1;
                    end
                    else if (req_reg == REQ_DELETE)
                    begin
                        alloc_reg[t_idx] <= 1'b0;
                    end
                end
                OP_EMIT:
                begin
                    armed_reg[w_idx] <= 1'b0;
                    out_valid_reg    <= 1'b1;
                end
                OP_STATUS:  out_valid_reg <= 1'b1;
                default:    level_reg <= level_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                req_reg   <= in_req;
                id_reg    <= in_id;
                delay_reg <= in_delay;
                data_reg  <= in_data;
                t_reg     <= LINK_W'(in_id);
            end
            OP_SET:       exp_reg <= new_exp;
            OP_PL_RD:     s_reg   <= place_s;
            OP_UNLINK_LD:
            begin
                p_reg <= rd_prev;
                n_reg <= rd_next;
                s_reg <= rd_slot;
            end
            OP_CS_RD:     s_reg <= coarse_s;
            OP_TK_RD:     s_reg <= root_s;
            OP_HD_CLR:    w_reg <= rd_head;
            OP_CW_LD:
            begin
                nn_reg  <= rd_next;
                t_reg   <= w_reg;
                exp_reg <= rd_exp;
            end
            OP_W_ADV:     w_reg <= nn_reg;
            OP_EMIT:
            begin
                w_reg          <= rd_next;
                out_kind_reg   <= KIND_EXPIRE;
                out_status_reg <= ST_OK;
                out_id_reg     <= ID_W'(w_reg);
                out_data_reg   <= rd_pay;
                out_last_reg   <= (rd_next == NIL);
            end
            OP_STATUS:
            begin
                out_kind_reg   <= KIND_STATUS;
                out_status_reg <= cmd.code;
                out_id_reg     <= id_reg;
                out_data_reg   <= '0;
                out_last_reg   <= 1'b1;
            end
            default:      w_reg <= w_reg;
        endcase
    end

    assign stat.clr_done   = (clr_reg == SLOT_W'(NSLOTS - 1));
    assign stat.req        = req_reg;
    assign stat.id_bad     = ({1'b0, id_reg} >= 7'(MAX_TIMERS));
    assign stat.armed      = armed_reg[t_idx];
    assign stat.alloc      = alloc_reg[t_idx];
    assign stat.exp_eq     = (rd_exp == new_exp);
    assign stat.w_nil      = (w_reg == NIL);
    assign stat.idx_zero   = (cidx == 64'd0);
    assign stat.level_last = (level_reg == LEVEL_W'(LEVELS - 1));
    assign stat.ri_zero    = (root_s == '0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;

endmodule

[design/htw_control.sv]
// Timer wheel sequencer: steps requests, cascades and expiries through the datapath.
`timescale 1ns / 1ps
module htw_control (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  htw_pkg::stat_t stat,
    output htw_pkg::cmd_t  cmd
);
    import htw_pkg::*;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_RD_T,
        S_CHK,
        S_UL_LD,
        S_UL_WR,
        S_SET,
        S_PL_RD,
        S_PL_WR,
        S_STAT,
        S_CS_RD,
        S_CS_CLR,
        S_CW_CHK,
        S_CW_RD,
        S_CW_LD,
        S_W_ADV,
        S_TK_RD,
        S_TK_CLR,
        S_FW_CHK,
        S_FW_RD,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    logic                casc_reg, casc_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        casc_next  = casc_reg;
        cmd.op       = OP_NONE;
        cmd.code     = code_reg;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                code_next = ST_OK;
                priority if (stat.req == REQ_TICK)
                begin
                    casc_next  = stat.ri_zero;
                    state_next = stat.ri_zero ? S_CS_RD : S_TK_RD;
                end
                else if (stat.id_bad)
                begin
                    code_next  = ST_UNALLOC;
                    state_next = S_STAT;
                end
                else if (stat.req == REQ_ADD)
                begin
                    if (stat.armed)
                    begin
                        code_next  = ST_ACTIVE;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        state_next = S_SET;
                    end
                end
                else if (!stat.alloc)
                begin
                    code_next  = ST_UNALLOC;
                    state_next = S_STAT;
                end
                else if (stat.req == REQ_MODIFY || stat.armed)
                begin
                    state_next = S_RD_T;
                end
                else
                begin
                    state_next = S_SET;
                end
            end
            S_RD_T:
            begin
                cmd.op     = OP_RD_T;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (stat.req == REQ_DELETE)
                begin
                    state_next = S_UL_LD;
                end
                else if (stat.armed && stat.exp_eq)
                begin
                    state_next = S_STAT;
                end
                else
                begin
                    state_next = stat.armed ? S_UL_LD : S_SET;
                end
            end
            S_UL_LD:
            begin
                cmd.op     = OP_UNLINK_LD;
                state_next = S_UL_WR;
            end
            S_UL_WR:
            begin
                cmd.op     = OP_UNLINK_WR;
                state_next = S_SET;
            end
            S_SET:
            begin
                cmd.op     = OP_SET;
                state_next = (stat.req == REQ_DELETE) ? S_STAT : S_PL_RD;
            end
            S_PL_RD:
            begin
                cmd.op     = OP_PL_RD;
                state_next = S_PL_WR;
            end
            S_PL_WR:
            begin
                cmd.op     = OP_PL_WR;
                state_next = casc_reg ? S_W_ADV : S_STAT;
            end
            S_STAT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_STATUS;
                    state_next = S_IDLE;
                end
            end
            S_CS_RD:
            begin
                cmd.op     = OP_CS_RD;
                state_next = S_CS_CLR;
            end
            S_CS_CLR:
            begin
                cmd.op     = OP_HD_CLR;
                state_next = S_CW_CHK;
            end
            S_CW_CHK:
            begin
                priority if (!stat.w_nil)
                begin
                    state_next = S_CW_RD;
                end
                else if (stat.idx_zero && !stat.level_last)
                begin
                    cmd.op     = OP_LVL_INC;
                    state_next = S_CS_RD;
                end
                else
                begin
                    state_next = S_TK_RD;
                end
            end
            S_CW_RD:
            begin
                cmd.op     = OP_W_RD;
                state_next = S_CW_LD;
            end
            S_CW_LD:
            begin
                cmd.op     = OP_CW_LD;
                state_next = S_PL_RD;
            end
            S_W_ADV:
            begin
                cmd.op     = OP_W_ADV;
                state_next = S_CW_CHK;
            end
            S_TK_RD:
            begin
                cmd.op     = OP_TK_RD;
                casc_next  = 1'b0;
                state_next = S_TK_CLR;
            end
            S_TK_CLR:
            begin
                cmd.op     = OP_HD_CLR;
                state_next = S_FW_CHK;
            end
            S_FW_CHK:
            begin
                state_next = stat.w_nil ? S_IDLE : S_FW_RD;
            end
            S_FW_RD:
            begin
                cmd.op     = OP_W_RD;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_FW_CHK;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            code_reg  <= ST_OK;
            casc_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            casc_reg  <= casc_next;
        end
    end

endmodule

[design/hierarchical_timer_wheel.sv]
// Top level of the five-level hierarchical timer wheel.
//
//   channel | dir | tdata (low bit first)               | tuser    | tlast
//   s_      | in  | timer_id, delay, user_data          | req_type | -
//   m_      | out | status, expired_id, expired_data    | kind     | last
//
// After reset a clearing pass empties all 2^ROOT_BITS + 4 * 2^LEVEL_BITS
// slot lists (512 by default); s_tready stays low meanwhile.
// Add, modify and delete each end with one status transfer on the m_ side.
// A tick cascades the due coarser slots when the root index is zero, then
// emits one transfer per expired timer. A stalled m_ side holds the sequencer.
`timescale 1ns / 1ps
module hierarchical_timer_wheel #(
    parameter int ROOT_BITS  = htw_pkg::DEF_ROOT_BITS,
    parameter int LEVEL_BITS = htw_pkg::DEF_LEVEL_BITS,
    parameter int MAX_TIMERS = htw_pkg::DEF_MAX_TIMERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // timer_id, delay, user_data, zero fill
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status, expired_id, expired_data
    output logic [0:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import htw_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic                out_kind;
    logic [STATUS_W-1:0] out_status;
    logic [ID_W-1:0]     out_id;
    logic [DATA_W-1:0]   out_data;

    htw_control u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    htw_datapath #(
        .ROOT_BITS  (ROOT_BITS),
        .LEVEL_BITS (LEVEL_BITS),
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (s_tuser),
        .in_id      (s_tdata[5:0]),
        .in_delay   (s_tdata[36:6]),
        .in_data    (s_tdata[68:37]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_kind   (out_kind),
        .out_status (out_status),
        .out_id     (out_id),
        .out_data   (out_data),
        .out_last   (m_tlast)
    );

    assign s_tready   = cmd.in_ready;
    assign m_tdata    = {out_data, out_id, out_status};
    assign m_tuser[0] = out_kind;

endmodule

[design/htw_check.sv]
// Port checker for the hierarchical timer wheel, bound to the top level.
`timescale 1ns / 1ps
module htw_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("status transfer without last");

    a_expire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == 2'd0)
        else $error("expiry transfer with nonzero status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[39:8] == 32'd0)
        else $error("status transfer carries data");

endmodule

bind hierarchical_timer_wheel htw_check u_htw_check (.*);

[sim/tb_hierarchical_timer_wheel.sv]
// Testbench for the hierarchical timer wheel: directed and random stream stimulus checked against a predictor.
`timescale 1ns / 1ps
module tb_hierarchical_timer_wheel;
    import htw_pkg::*;

    localparam int RB = DEF_ROOT_BITS;
    localparam int LB = DEF_LEVEL_BITS;
    localparam int NT = DEF_MAX_TIMERS;
    localparam int RS = 1 << RB;
    localparam int LS = 1 << LB;
    localparam int NSLOT = RS + LEVELS * LS;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [DATA_W-1:0]   data;
        logic                last;
    } wheel_result_t;

    class wheel_scoreboard;
        logic [TIME_W-1:0] now_ticks;
        logic [TIME_W-1:0] expiry [NT];
        logic [DATA_W-1:0] payload [NT];
        bit                armed [NT];
        bit                alloc [NT];
        logic [LINK_W-1:0] nxt [NT];
        logic [LINK_W-1:0] prv [NT];
        int                slot_of [NT];
        logic [LINK_W-1:0] head [NSLOT];
        logic [LINK_W-1:0] tail [NSLOT];
        wheel_result_t     pending [$];
        int                errors;

        function void clear();
            now_ticks = '0;
            errors = 0;
            for (int i = 0; i < NT; i++)
            begin
                expiry[i] = '0;
                payload[i] = '0;
                armed[i] = 0;
                alloc[i] = 0;
                nxt[i] = NIL;
                prv[i] = NIL;
                slot_of[i] = 0;
            end
            for (int s = 0; s < NSLOT; s++)
            begin
                head[s] = NIL;
                tail[s] = NIL;
            end
        endfunction

        function void place(int t);
            logic [TIME_W-1:0] gap;
            logic [TIME_W-1:0] e;
            longint unsigned d;
            int s;
            gap = expiry[t] - now_ticks;
            e = expiry[t];
            d = {32'd0, gap};
            if (gap[31])
                s = now_ticks & (RS - 1);
            else if (d < (64'd1 << RB))
                s = e & (RS - 1);
            else if (d < (64'd1 << (RB + LB)))
                s = RS + ((e >> RB) & (LS - 1));
            else if (d < (64'd1 << (RB + 2 * LB)))
                s = RS + LS + ((e >> (RB + LB)) & (LS - 1));
            else if (d < (64'd1 << (RB + 3 * LB)))
                s = RS + 2 * LS + ((e >> (RB + 2 * LB)) & (LS - 1));
            else
                s = RS + 3 * LS + ((e >> (RB + 3 * LB)) & (LS - 1));
            slot_of[t] = s;
            nxt[t] = NIL;
            prv[t] = tail[s];
            if (tail[s] == NIL)
                head[s] = LINK_W'(t);
            else
                nxt[tail[s]] = LINK_W'(t);
            tail[s] = LINK_W'(t);
        endfunction

        function void unlink(int t);
            int s;
            logic [LINK_W-1:0] p;
            logic [LINK_W-1:0] n;
            s = slot_of[t];
            p = prv[t];
            n = nxt[t];
            if (p == NIL)
                head[s] = n;
            else
                nxt[p] = n;
            if (n == NIL)
                tail[s] = p;
            else
                prv[n] = p;
            nxt[t] = NIL;
            prv[t] = NIL;
        endfunction

        function int coarse_idx(int lvl);
            return (now_ticks >> (RB + lvl * LB)) & (LS - 1);
        endfunction

        function int cascade(int lvl, int idx);
            int s;
            logic [LINK_W-1:0] w;
            logic [LINK_W-1:0] n;
            s = RS + lvl * LS + idx;
            w = head[s];
            head[s] = NIL;
            tail[s] = NIL;
            while (w != NIL)
            begin
                n = nxt[w];
                place(w);
                w = n;
            end
            return idx;
        endfunction

        function void note(logic [REQ_W-1:0] req, int id, logic [DELAY_W-1:0] delay,
                           logic [DATA_W-1:0] data);
            wheel_result_t r;
            logic [STATUS_W-1:0] st;
            logic [TIME_W-1:0] ne;
            logic [LINK_W-1:0] w;
            logic [LINK_W-1:0] n;
            int ri;
            st = ST_OK;
            if (req == REQ_TICK)
            begin
                ri = now_ticks & (RS - 1);
                if (ri == 0 && cascade(0, coarse_idx(0)) == 0 &&
                    cascade(1, coarse_idx(1)) == 0 && cascade(2, coarse_idx(2)) == 0)
                    void'(cascade(3, coarse_idx(3)));
                now_ticks = now_ticks + 1;
                w = head[ri];
                head[ri] = NIL;
                tail[ri] = NIL;
                while (w != NIL)
                begin
                    n = nxt[w];
                    nxt[w] = NIL;
                    prv[w] = NIL;
                    armed[w] = 0;
                    r.kind = KIND_EXPIRE;
                    r.status = ST_OK;
                    r.id = w[ID_W-1:0];
                    r.data = payload[w];
                    r.last = (n == NIL);
                    pending.push_back(r);
                    w = n;
                end
                return;
            end
            if (req == REQ_ADD)
            begin
                if (armed[id])
                    st = ST_ACTIVE;
                else
                begin
                    alloc[id] = 1;
                    payload[id] = data;
                    expiry[id] = now_ticks + delay;
                    armed[id] = 1;
                    place(id);
                end
            end
            else if (!alloc[id])
                st = ST_UNALLOC;
            else if (req == REQ_MODIFY)
            begin
                ne = now_ticks + delay;
                if (!(armed[id] && expiry[id] == ne))
                begin
                    if (armed[id])
                        unlink(id);
                    expiry[id] = ne;
                    armed[id] = 1;
                    place(id);
                end
            end
            else
            begin
                if (armed[id])
                    unlink(id);
                armed[id] = 0;
                alloc[id] = 0;
            end
            r.kind = KIND_STATUS;
            r.status = st;
            r.id = ID_W'(id);
            r.data = '0;
            r.last = 1'b1;
            pending.push_back(r);
        endfunction

        function void check(wheel_result_t got);
            wheel_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                $display("%0t: kind exp %h got %h", $time, want.kind, got.kind);
            if (got.status !== want.status)
                $display("%0t: status exp %h got %h", $time, want.status, got.status);
            if (got.id !== want.id)
                $display("%0t: id exp %h got %h", $time, want.id, got.id);
            if (got.data !== want.data)
                $display("%0t: data exp %h got %h", $time, want.data, got.data);
            if (got.last !== want.last)
                $display("%0t: last exp %h got %h", $time, want.last, got.last);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    wheel_scoreboard sb;
    int idle_cycles;
    int results_seen;
    int burst_left;
    bit hold_done;

    hierarchical_timer_wheel DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note(s_tuser, s_tdata[5:0], s_tdata[36:6], s_tdata[68:37]);
            if (m_tvalid && m_tready)
            begin
                sb.check({m_tuser[0], m_tdata[1:0], m_tdata[7:2], m_tdata[39:8], m_tlast});
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        int mode_left;
        bit busy_mode;
        m_tready = 0;
        hold = 0;
        mode_left = 0;
        busy_mode = 0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 40)
            begin
                hold_done = 1;
                hold = 400;
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(10, 60);
                busy_mode = $urandom_range(0, 1);
            end
            mode_left--;
            if (hold > 0)
            begin
                hold--;
                m_tready = 0;
            end
            else
                m_tready = busy_mode ? ($urandom_range(0, 9) < 6) : 1'b1;
        end
    end

    task send(logic [REQ_W-1:0] req, logic [ID_W-1:0] id, logic [DELAY_W-1:0] delay,
              logic [DATA_W-1:0] data);
        s_tuser = req;
        s_tdata = {3'b000, data, delay, id};
        s_tvalid = 1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid = 0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task send_random();
        int r;
        logic [ID_W-1:0] id;
        logic [DELAY_W-1:0] dl;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 63))
                                         : ID_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0: dl = DELAY_W'($urandom);
            1: dl = DELAY_W'($urandom_range(200, 700));
            default: dl = DELAY_W'($urandom_range(0, 40));
        endcase
        if (r < 72)
            send(REQ_TICK, ID_W'($urandom), DELAY_W'($urandom), $urandom);
        else if (r < 86)
            send(REQ_ADD, id, dl, $urandom);
        else if (r < 93)
            send(REQ_MODIFY, id, dl, $urandom);
        else
            send(REQ_DELETE, id, dl, $urandom);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        idle_cycles = 0;
        results_seen = 0;
        burst_left = 0;
        hold_done = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = REQ_ADD;
        rst_n = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(REQ_ADD, 6'd0, 31'd0, 32'hffffffff);
        send(REQ_ADD, 6'd0, 31'd5, 32'h12345678);
        send(REQ_TICK, 6'd0, 31'd0, 32'd0);
        send(REQ_MODIFY, 6'd5, 31'd1, 32'd0);
        send(REQ_DELETE, 6'd5, 31'd0, 32'd0);
        send(REQ_ADD, 6'd1, 31'd2, 32'h0000_0001);
        send(REQ_MODIFY, 6'd1, 31'd2, 32'd0);
        send(REQ_MODIFY, 6'd1, 31'd1, 32'd0);
        send(REQ_ADD, 6'd63, 31'h7fffffff, 32'h0);
        send(REQ_ADD, 6'd2, 31'd256, 32'haaaa5555);
        send(REQ_ADD, 6'd3, 31'd20000, 32'h5555aaaa);
        send(REQ_ADD, 6'd4, 31'd3000000, 32'h0f0f0f0f);
        send(REQ_ADD, 6'd6, 31'd3, 32'h600d600d);
        send(REQ_DELETE, 6'd6, 31'd0, 32'd0);
        send(REQ_ADD, 6'd6, 31'd1, 32'hdeadbeef);
        send(REQ_ADD, 6'd7, 31'd1, 32'hcafef00d);
        send(REQ_TICK, 6'd0, 31'd0, 32'd0);
        send(REQ_TICK, 6'd0, 31'd0, 32'd0);
        send(REQ_MODIFY, 6'd0, 31'd0, 32'd0);
        send(REQ_TICK, 6'd0, 31'd0, 32'd0);
        send(REQ_DELETE, 6'd63, 31'd0, 32'd0);
        send(REQ_DELETE, 6'd63, 31'd0, 32'd0);
        send(REQ_ADD, 6'd0, 31'd0, 32'h80000000);

        for (int i = 0; i < 247; i++)
            send_random();

        s_tvalid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
